// ===== hdl/i2cw_pkg.sv =====
// Package for the three-byte I2C write master.
// Holds the phase codes, register indexes, state and item types, reset constants.
// Used by the top level, i2cw_csr, i2cw_core and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package i2cw_pkg;

   // Line phases of the bit-level sequencer
   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_START_FALL = 4'd1,
      PH_START_LOW  = 4'd2,
      PH_BIT_SET    = 4'd3,
      PH_BIT_HIGH   = 4'd4,
      PH_BIT_LOW    = 4'd5,
      PH_ACK_REL    = 4'd6,
      PH_ACK_HIGH   = 4'd7,
      PH_ACK_LOW    = 4'd8,
      PH_STOP_SDA0  = 4'd9,
      PH_STOP_SCL1  = 4'd10,
      PH_STOP_SDA1  = 4'd11,
      PH_STOP_SCL0  = 4'd12
   } phase_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_CONTROL_BYTE   = 1'b1
   } csr_index_type;

   // Item kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Byte slots
   localparam logic [1:0] SLOT_ADDRESS = 2'd0;
   localparam logic [1:0] SLOT_CONTROL = 2'd1;
   localparam logic [1:0] SLOT_DATA    = 2'd2;

   localparam logic [2:0] LAST_BIT = 3'd7;

   // Register reset values
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h90;
   localparam logic [7:0] CONTROL_BYTE_RESET   = 8'h40;

   localparam int REQ_TDATA_WIDTH = 16;
   localparam int RSP_TDATA_WIDTH = 8;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] control_byte;
   } cfg_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic scl_out;
      logic sda_out;
      logic busy_res;
      logic done_res;
      logic ack_error;
   } rsp_item_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] byte_slot;
      logic [2:0] bit_count;
      logic [7:0] shift_byte;
      logic [7:0] held_data;
      logic       clock_level;
      logic       data_level;
      logic       nack_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_IDLE,
      byte_slot:   SLOT_ADDRESS,
      bit_count:   3'd0,
      shift_byte:  8'h00,
      held_data:   8'h00,
      clock_level: 1'b1,
      data_level:  1'b1,
      nack_seen:   1'b0
   };

endpackage

`default_nettype wire

// ===== hdl/i2c_master_three_byte_write.sv =====
// Bit-level I2C master that writes an address, a control byte and a data byte.
// Top level: input register, sequencer, result register. Uses i2cw_pkg,
// i2cw_csr and i2cw_core.
//
// Usage:
//  - req channel: each transfer is one item. tuser = 1 starts a write (idle only,
//    otherwise it counts as a tick); tuser = 0 is a tick that advances one line
//    phase. tdata carries the data byte and the sampled SDA level.
//  - rsp channel: one item per request item, in order, carrying the line levels
//    to drive, busy and the sticky NACK flag; tlast marks the item that ends
//    a transfer (after the stop, or right after a NACK with no stop).
//  - csr channel: writes device_address (index 0) and control_byte (index 1),
//    always ready; write it only while no write is under way.
//  - rsp_tvalid rises once the input register has loaded on the req transfer
//    and the result register has loaded from it; a held result stalls the second load.
//    Throughput: one item per cycle while results are taken, set by the single pass of
//    next-phase logic between the two registers.
//  - Reset: both lines released (SCL and SDA high), sequencer idle, registers
//    back to 0x90 and 0x40, both stages empty.
//  - Stall: a held rsp item keeps its data; req_tready drops only once both
//    the input and the result register are occupied.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_three_byte_write
   import i2cw_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,  // [7:0] data_byte, [8] sda_in, rest 0
   input  wire logic                       req_tuser,  // [0] opcode
   // result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata,  // [0] scl_out, [1] sda_out,
                                                       // [2] busy_res, [3] ack_error, rest 0
   output logic                            rsp_tlast,  // done_res
   // configuration write channel
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [7:0]                 csr_wdata
);

   logic         req_fire;
   logic         stage_move;
   logic         rsp_free;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   req_item_type in_item_in;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   cfg_type      cfg;

   // Configuration registers are always ready
   assign csr_ready = 1'b1;

   i2cw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_valid & csr_ready),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the input stage when the result register is empty or being taken
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign stage_move = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.opcode    = req_tuser;
      in_item_in.data_byte = req_tdata[7:0];
      in_item_in.sda_in    = req_tdata[8];

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (stage_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      if (stage_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Sequencer steps once per item leaving the input register
   i2cw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_move),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (rsp_item_in)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff.ack_error, rsp_item_ff.busy_res,
                        rsp_item_ff.sda_out, rsp_item_ff.scl_out};
   assign rsp_tlast  = rsp_item_ff.done_res;

endmodule

`default_nettype wire

// ===== hdl/i2cw_csr.sv =====
// Configuration registers of the three-byte I2C write master.
// Depends on i2cw_pkg for register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_csr
   import i2cw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_fire,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_wdata,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            CSR_CONTROL_BYTE:   cfg_in.control_byte   = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.control_byte   <= CONTROL_BYTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/i2cw_core.sv =====
// Line-phase sequencer of the three-byte I2C write master.
// Holds the transfer state and forms one result per processed item.
// Depends on i2cw_pkg for phase codes, state and item types.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_core
   import i2cw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   state_type state_ff;
   state_type state_in;
   logic      done;

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      if (item.opcode == OP_REQUEST && state_ff.phase == PH_IDLE) begin
         // latch the data byte and release both lines
         state_in.held_data   = item.data_byte;
         state_in.nack_seen   = 1'b0;
         state_in.byte_slot   = SLOT_ADDRESS;
         state_in.bit_count   = 3'd0;
         state_in.data_level  = 1'b1;
         state_in.clock_level = 1'b1;
         state_in.phase       = PH_START_FALL;
      end else begin
         case (state_ff.phase)
            PH_IDLE: begin
               state_in = state_ff;
            end
            PH_START_FALL: begin
               state_in.data_level = 1'b0;
               state_in.phase      = PH_START_LOW;
            end
            PH_START_LOW: begin
               state_in.clock_level = 1'b0;
               state_in.byte_slot   = SLOT_ADDRESS;
               state_in.bit_count   = 3'd0;
               state_in.shift_byte  = cfg.device_address;
               state_in.phase       = PH_BIT_SET;
            end
            PH_BIT_SET: begin
               state_in.data_level = state_ff.shift_byte[7];
               state_in.phase      = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
               state_in.clock_level = 1'b1;
               state_in.phase       = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               state_in.clock_level = 1'b0;
               state_in.shift_byte  = {state_ff.shift_byte[6:0], 1'b0};
               if (state_ff.bit_count == LAST_BIT) begin
                  state_in.bit_count = 3'd0;
                  state_in.phase     = PH_ACK_REL;
               end else begin
                  state_in.bit_count = 3'(state_ff.bit_count + 3'd1);
                  state_in.phase     = PH_BIT_SET;
               end
            end
            PH_ACK_REL: begin
               state_in.data_level = 1'b1;
               state_in.phase      = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               state_in.clock_level = 1'b1;
               state_in.nack_seen   = item.sda_in;
               state_in.phase       = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
               state_in.clock_level = 1'b0;
               if (state_ff.nack_seen) begin
                  // drop the transfer, no stop
                  done           = 1'b1;
                  state_in.phase = PH_IDLE;
               end else if (state_ff.byte_slot == SLOT_ADDRESS) begin
                  state_in.byte_slot  = SLOT_CONTROL;
                  state_in.shift_byte = cfg.control_byte;
                  state_in.phase      = PH_BIT_SET;
               end else if (state_ff.byte_slot == SLOT_CONTROL) begin
                  state_in.byte_slot  = SLOT_DATA;
                  state_in.shift_byte = state_ff.held_data;
                  state_in.phase      = PH_BIT_SET;
               end else begin
                  state_in.phase = PH_STOP_SDA0;
               end
            end
            PH_STOP_SDA0: begin
               state_in.data_level = 1'b0;
               state_in.phase      = PH_STOP_SCL1;
            end
            PH_STOP_SCL1: begin
               state_in.clock_level = 1'b1;
               state_in.phase       = PH_STOP_SDA1;
            end
            PH_STOP_SDA1: begin
               state_in.data_level = 1'b1;
               state_in.phase      = PH_STOP_SCL0;
            end
            PH_STOP_SCL0: begin
               state_in.clock_level = 1'b0;
               done                 = 1'b1;
               state_in.phase       = PH_IDLE;
            end
            default: begin
               state_in.phase = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      result.scl_out   = state_in.clock_level;
      result.sda_out   = state_in.data_level;
      result.busy_res  = (state_in.phase != PH_IDLE);
      result.done_res  = done;
      result.ack_error = state_in.nack_seen;
   end

endmodule

`default_nettype wire

// ===== hdl/i2cw_checker.sv =====
// Port-level checker for the three-byte I2C write master, with its bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // The result stage is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A held result keeps its contents
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The ending item leaves the sequencer idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[2])
      else $error("transfer ended but still busy");

   // Every transfer ends with SCL low
   a_done_scl_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[0])
      else $error("transfer ended with SCL high");

endmodule

bind i2c_master_three_byte_write i2cw_checker u_i2cw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_i2c_master_three_byte_write.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the three-byte I2C write master.
// Drives request, tick and register transfers and checks every result item.
// Results are checked against a line-level predictor. Depends on i2cw_pkg and the RTL.

module tb_i2c_master_three_byte_write;
   import i2cw_pkg::*;

   // Longest quiet stretch in a correct run is the long receiver hold-off;
   // the watchdog allows several times that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLDOFF   = 300;
   // Two register stages between req and rsp; the drain wait covers them with margin.
   localparam int DRAIN_CYCLES   = 4;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;   // [7:0] data_byte, [8] sda_in
   logic                       req_tuser  = OP_TICK;  // [0] opcode
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;  // [0] scl_out, [1] sda_out, [2] busy_res, [3] ack_error
   logic                       rsp_tlast;  // done_res
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   csr_index_type              csr_index  = CSR_DEVICE_ADDRESS;
   logic [7:0]                 csr_wdata  = '0;

   i2c_master_three_byte_write u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the sequencer and its registers, advanced once per accepted transfer
   state_type    line_state = STATE_RESET;
   cfg_type      cfg_shadow = '{DEVICE_ADDRESS_RESET, CONTROL_BYTE_RESET};
   rsp_item_type expected_lines[$];

   int error_count     = 0;
   bit req_idle_enable = 1'b1;
   bit rsp_idle_enable = 1'b1;
   int holdoff_token   = 0;   // bumped by the test sequence to request a long hold-off
   int holdoff_seen    = 0;
   int rsp_hold_cnt    = 0;
   int quiet_cycles    = 0;

   // Advance the line model by one accepted transfer and return the item it should produce.
   function automatic rsp_item_type predict_line_step(input logic op, input logic [7:0] data,
                                                      input logic sda);
      rsp_item_type line_item;
      logic         ends;
      ends = 1'b0;
      if (op == OP_REQUEST && line_state.phase == PH_IDLE) begin
         // a request is taken only while idle: latch the data byte, release both lines
         line_state.held_data   = data;
         line_state.nack_seen   = 1'b0;
         line_state.byte_slot   = SLOT_ADDRESS;
         line_state.bit_count   = 3'd0;
         line_state.data_level  = 1'b1;
         line_state.clock_level = 1'b1;
         line_state.phase       = PH_START_FALL;
      end else begin
         case (line_state.phase)
            PH_IDLE: ;
            PH_START_FALL: begin
               line_state.data_level = 1'b0;
               line_state.phase      = PH_START_LOW;
            end
            PH_START_LOW: begin
               line_state.clock_level = 1'b0;
               line_state.byte_slot   = SLOT_ADDRESS;
               line_state.bit_count   = 3'd0;
               line_state.shift_byte  = cfg_shadow.device_address;
               line_state.phase       = PH_BIT_SET;
            end
            PH_BIT_SET: begin
               line_state.data_level = line_state.shift_byte[7];
               line_state.phase      = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
               line_state.clock_level = 1'b1;
               line_state.phase       = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               line_state.clock_level = 1'b0;
               line_state.shift_byte  = line_state.shift_byte << 1;
               if (line_state.bit_count == LAST_BIT) begin
                  line_state.bit_count = 3'd0;
                  line_state.phase     = PH_ACK_REL;
               end else begin
                  line_state.bit_count = line_state.bit_count + 3'd1;
                  line_state.phase     = PH_BIT_SET;
               end
            end
            PH_ACK_REL: begin
               line_state.data_level = 1'b1;
               line_state.phase      = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               line_state.clock_level = 1'b1;
               line_state.nack_seen   = sda;
               line_state.phase       = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
               line_state.clock_level = 1'b0;
               if (line_state.nack_seen) begin
                  // no acknowledge: end right here, no stop
                  ends             = 1'b1;
                  line_state.phase = PH_IDLE;
               end else if (line_state.byte_slot == SLOT_ADDRESS) begin
                  line_state.byte_slot  = SLOT_CONTROL;
                  line_state.shift_byte = cfg_shadow.control_byte;
                  line_state.phase      = PH_BIT_SET;
               end else if (line_state.byte_slot == SLOT_CONTROL) begin
                  line_state.byte_slot  = SLOT_DATA;
                  line_state.shift_byte = line_state.held_data;
                  line_state.phase      = PH_BIT_SET;
               end else begin
                  line_state.phase = PH_STOP_SDA0;
               end
            end
            PH_STOP_SDA0: begin
               line_state.data_level = 1'b0;
               line_state.phase      = PH_STOP_SCL1;
            end
            PH_STOP_SCL1: begin
               line_state.clock_level = 1'b1;
               line_state.phase       = PH_STOP_SDA1;
            end
            PH_STOP_SDA1: begin
               line_state.data_level = 1'b1;
               line_state.phase      = PH_STOP_SCL0;
            end
            PH_STOP_SCL0: begin
               line_state.clock_level = 1'b0;
               ends                   = 1'b1;
               line_state.phase       = PH_IDLE;
            end
            default: line_state.phase = PH_IDLE;
         endcase
      end
      line_item.scl_out   = line_state.clock_level;
      line_item.sda_out   = line_state.data_level;
      line_item.busy_res  = (line_state.phase != PH_IDLE);
      line_item.done_res  = ends;
      line_item.ack_error = line_state.nack_seen;
      return line_item;
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare one accepted result item against the oldest expectation.
   function automatic void check_line_item();
      rsp_item_type want;
      if (expected_lines.size() == 0) begin
         $error("result item with no transfer outstanding");
         error_count++;
      end else begin
         want = expected_lines.pop_front();
         check_field("scl_out",   want.scl_out,   rsp_tdata[0]);
         check_field("sda_out",   want.sda_out,   rsp_tdata[1]);
         check_field("busy_res",  want.busy_res,  rsp_tdata[2]);
         check_field("ack_error", want.ack_error, rsp_tdata[3]);
         check_field("done_res",  want.done_res,  rsp_tlast);
      end
   endfunction

   // Receiver: check on each accepted transfer, then pick tready for the next edge.
   // A long hold-off lets the block fill up and stall its input.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_line_item();
      if (holdoff_token != holdoff_seen) begin
         holdoff_seen <= holdoff_token;
         rsp_hold_cnt <= LONG_HOLDOFF - 1;
         rsp_tready   <= 1'b0;
      end else if (rsp_hold_cnt != 0) begin
         rsp_hold_cnt <= rsp_hold_cnt - 1;
         rsp_tready   <= 1'b0;
      end else if (rsp_idle_enable && $urandom_range(7) == 0) begin
         // start an idle burst: drop tready and load the hold counter with a random value
         rsp_hold_cnt <= $urandom_range(9);
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one item, hold it until accepted, record its prediction, then maybe idle.
   // tvalid stays high when the next item follows at once.
   task automatic send_item(input logic op, input logic [7:0] data, input logic sda);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_WIDTH'({sda, data});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_lines.push_back(predict_line_step(op, data, sda));
      if (req_idle_enable && $urandom_range(5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
      end
   endtask

   // Sampled SDA level: mostly acknowledge in the ack slot, anything elsewhere.
   function automatic logic pick_sda();
      if (line_state.phase == PH_ACK_HIGH)
         return ($urandom_range(7) == 0);
      return logic'($urandom_range(1));
   endfunction

   // Mostly well-formed writes with random content; some idle ticks and
   // requests while busy as noise, NACKs as broken sequences.
   task automatic run_traffic(input int n_items);
      for (int n = 0; n < n_items; n++) begin
         if (line_state.phase == PH_IDLE) begin
            if ($urandom_range(15) == 0)
               send_item(OP_TICK, 8'($urandom), logic'($urandom_range(1)));
            else
               send_item(OP_REQUEST, 8'($urandom), logic'($urandom_range(1)));
         end else if ($urandom_range(31) == 0) begin
            send_item(OP_REQUEST, 8'($urandom), pick_sda());
         end else begin
            send_item(OP_TICK, 8'($urandom), pick_sda());
         end
      end
   endtask

   // Tick until the sequencer is idle again.
   task automatic finish_transfer();
      while (line_state.phase != PH_IDLE)
         send_item(OP_TICK, 8'($urandom), pick_sda());
   endtask

   // Drop valid and wait until every expected result has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register transfer; valid is left high for a following write.
   task automatic csr_transfer(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_DEVICE_ADDRESS)
         cfg_shadow.device_address = value;
      else
         cfg_shadow.control_byte = value;
   endtask

   // Bring the block idle and write both registers.
   task automatic configure(input logic [7:0] address, input logic [7:0] control);
      finish_transfer();
      wait_drained();
      csr_transfer(CSR_DEVICE_ADDRESS, address);
      csr_transfer(CSR_CONTROL_BYTE, control);
      csr_valid <= 1'b0;
   endtask

   // Ticks while idle after reset: both lines held released.
   task automatic test_idle_ticks();
      send_item(OP_TICK, 8'h00, 1'b0);
      send_item(OP_TICK, 8'hFF, 1'b1);
   endtask

   // Request, a second request while busy (taken as a tick), then no acknowledge
   // on the address byte; one idle tick shows the lines left after a NACK.
   task automatic test_nack_on_address();
      send_item(OP_REQUEST, 8'hFF, 1'b0);
      send_item(OP_REQUEST, 8'h00, 1'b1);
      while (line_state.phase != PH_IDLE)
         send_item(OP_TICK, 8'($urandom), 1'b1);
      send_item(OP_TICK, 8'hAA, 1'b0);
   endtask

   // Full writes with the reset registers, then with the register extremes.
   task automatic test_register_extremes();
      run_traffic(100);
      configure(8'h00, 8'hFF);
      run_traffic(150);
      configure(8'hFF, 8'h00);
      run_traffic(150);
   endtask

   task automatic test_random_settings();
      configure(8'($urandom), 8'($urandom));
      run_traffic(200);
   endtask

   // Hold the receiver off while the sender keeps offering items back to back.
   task automatic test_backpressure();
      req_idle_enable = 1'b0;
      holdoff_token <= holdoff_token + 1;
      run_traffic(60);
      req_idle_enable = 1'b1;
   endtask

   // Pause the sender mid-transfer until every expected result has come.
   task automatic test_sender_pause();
      run_traffic(30);
      wait_drained();
      run_traffic(70);
   endtask

   // Last stretch: no idling on either side.
   task automatic test_no_idle_tail();
      configure(DEVICE_ADDRESS_RESET, CONTROL_BYTE_RESET);
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      run_traffic(150);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_nack_on_address();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      test_sender_pause();
      test_no_idle_tail();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
